[src/lcta_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the load-cell block.
package lcta_pkg;

	localparam int MEASURE_AVERAGE_DEF = 3;
	localparam int TARE_AVERAGE_DEF    = 10;
	localparam int SAMPLE_BITS_DEF     = 24;

	localparam int KNOWN_W  = 16;
	localparam int WEIGHT_W = 40;
	localparam int SCALE_W  = 32;
	localparam int DVD_W    = 32;
	localparam int CNT_W    = 5;

	localparam logic [1:0] KIND_MEASURE = 2'd0;
	localparam logic [1:0] KIND_TARE    = 2'd1;
	localparam logic [1:0] KIND_CAL     = 2'd2;

	localparam logic signed [SCALE_W-1:0] SCALE_RESET = 32'sd2309489;
	localparam logic signed [SCALE_W-1:0] SCALE_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [SCALE_W-1:0] SCALE_MIN   = 32'sh8000_0000;

	typedef struct packed {
		logic in_ready;
		logic avg_mul;
		logic div_step;
		logic avg_fin;
		logic mul;
		logic cal_check;
		logic cal_fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       take_done;
		logic       div_last;
		logic [1:0] kind;
		logic       cal_reject;
		logic       out_free;
	} stat_t;

endpackage

[src/lcta_in_if.sv]
// Sample channel: one raw converter word per beat.
interface lcta_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [23:0] raw_sample;
	logic        sample_timed_out;
	logic [15:0] known_weight;

	modport source(output valid, kind, raw_sample, sample_timed_out, known_weight,
		input ready);
	modport sink(input valid, kind, raw_sample, sample_timed_out, known_weight,
		output ready);
endinterface

[src/lcta_out_if.sv]
// Result channel: one beat per finished run.
interface lcta_out_if;
	logic               valid;
	logic               ready;
	logic [39:0]        weight_q8;
	logic [1:0]         done_kind;
	logic               calibration_rejected;
	logic signed [31:0] scale_now;

	modport source(output valid, weight_q8, done_kind, calibration_rejected, scale_now,
		input ready);
	modport sink(input valid, weight_q8, done_kind, calibration_rejected, scale_now,
		output ready);
endinterface

[src/lcta_datapath.sv]
// Datapath: run accumulator, reciprocal average, calibration divider, scale multiplier, result register.
module lcta_datapath #(
	parameter int MEASURE_AVERAGE = lcta_pkg::MEASURE_AVERAGE_DEF,
	parameter int TARE_AVERAGE    = lcta_pkg::TARE_AVERAGE_DEF,
	parameter int SAMPLE_BITS     = lcta_pkg::SAMPLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	lcta_in_if.sink        sample_in,
	lcta_out_if.source     result_out,
	input  lcta_pkg::cmd_t cmd,
	output lcta_pkg::stat_t stat
);
	import lcta_pkg::*;

	localparam int SUM_W  = SAMPLE_BITS + 5;
	localparam int NET_W  = SAMPLE_BITS + 1;
	localparam int DVS_W  = NET_W;
	localparam int PROD_W = NET_W + SCALE_W;
	localparam int STEP_W = $clog2(DVD_W);
	localparam logic [DVD_W-1:0] DVD_HALF = {1'b1, {(DVD_W-1){1'b0}}};

	localparam int MAG_W    = SUM_W - 1;
	localparam int RECIP_SH = SUM_W + 3;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int AVG_P_W  = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MEASURE =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(MEASURE_AVERAGE - 1)) / 64'(MEASURE_AVERAGE));
	localparam logic [RECIP_W-1:0] RECIP_TARE =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(TARE_AVERAGE - 1)) / 64'(TARE_AVERAGE));

	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [SUM_W-1:0]       smp_x, sum_n, sum_q, sum_mag;
	logic [CNT_W-1:0]              cnt_q, cnt_n, need;
	logic [1:0]                    run_kind_q, kind_q;
	logic                          kind_ok, same_run, take, run_done;
	logic [KNOWN_W-1:0]            known_q;

	logic                 neg_q;
	logic [DVS_W-1:0]     dvs_q, rem_q;
	logic [DVD_W-1:0]     dq_q, quo_s;
	logic [STEP_W-1:0]    step_q;
	logic [DVS_W:0]       trial, trial_sub;
	logic                 ge;
	logic [RECIP_W-1:0]   recip;
	logic [AVG_P_W-1:0]   avg_prod;

	logic signed [SAMPLE_BITS-1:0] avg_w, offset_q;
	logic signed [NET_W-1:0]       net_q, net_n;
	logic [NET_W-1:0]              net_mag;
	logic signed [SCALE_W-1:0]     scale_q, scale_n;
	logic signed [PROD_W-1:0]      prod_q;
	logic                          rej_q, cal_reject, pos, sat;
	logic [WEIGHT_W-1:0]           weight_n;

	logic                      out_valid_q;
	logic [WEIGHT_W-1:0]       weight_q;
	logic [1:0]                done_kind_q;
	logic                      rejected_q;
	logic signed [SCALE_W-1:0] scale_out_q;

	// accumulation of the incoming beat
	assign smp      = sample_in.raw_sample[SAMPLE_BITS-1:0];
	assign smp_x    = sample_in.sample_timed_out ? '0 : SUM_W'(smp);
	assign kind_ok  = (sample_in.kind == KIND_MEASURE) || (sample_in.kind == KIND_TARE) ||
		(sample_in.kind == KIND_CAL);
	assign same_run = sample_in.kind == run_kind_q;
	assign sum_n    = (same_run ? sum_q : '0) + smp_x;
	assign cnt_n    = (same_run ? cnt_q : '0) + CNT_W'(1);
	assign need     = (sample_in.kind == KIND_MEASURE) ? CNT_W'(MEASURE_AVERAGE) :
		CNT_W'(TARE_AVERAGE);
	assign take     = sample_in.valid & cmd.in_ready;
	assign run_done = kind_ok && (cnt_n == need);
	assign sum_mag  = sum_n[SUM_W-1] ? -sum_n : sum_n;
	assign sample_in.ready = cmd.in_ready;

	// average magnitude = magnitude * ceil(2^RECIP_SH / n) >> RECIP_SH, exact over the sum range
	assign recip    = (kind_q == KIND_MEASURE) ? RECIP_MEASURE : RECIP_TARE;
	assign avg_prod = dq_q[MAG_W-1:0] * recip;

	// one quotient bit per step
	assign trial     = {rem_q, dq_q[DVD_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = trial >= {1'b0, dvs_q};

	assign quo_s   = neg_q ? -dq_q : dq_q;
	assign avg_w   = quo_s[SAMPLE_BITS-1:0];
	assign net_n   = NET_W'(avg_w) - NET_W'(offset_q);
	assign net_mag = net_q[NET_W-1] ? NET_W'(-net_q) : net_q;
	assign cal_reject = (net_q == '0) || (known_q == '0);

	always_comb begin
		if (!neg_q) begin
			scale_n = dq_q[DVD_W-1] ? SCALE_MAX : SCALE_W'(dq_q);
		end else begin
			scale_n = (dq_q > DVD_HALF) ? SCALE_MIN : SCALE_W'(-dq_q);
		end
	end

	assign pos = !prod_q[PROD_W-1] && (prod_q != '0);
	assign sat = |prod_q[PROD_W-1:WEIGHT_W+8];
	always_comb begin
		if (!pos || kind_q != KIND_MEASURE) begin
			weight_n = '0;
		end else if (sat) begin
			weight_n = '1;
		end else begin
			weight_n = prod_q[WEIGHT_W+7:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			run_kind_q  <= KIND_MEASURE;
			offset_q    <= '0;
			scale_q     <= SCALE_RESET;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && kind_ok) begin
				run_kind_q <= sample_in.kind;
				if (run_done) begin
					sum_q  <= '0;
					cnt_q  <= '0;
					step_q <= '0;
				end else begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
				end
			end
			if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.cal_check) begin
				step_q <= '0;
			end
			if (cmd.avg_fin && kind_q == KIND_TARE) begin
				offset_q <= avg_w;
			end
			if (cmd.cal_fin) begin
				scale_q <= scale_n;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && run_done) begin
			kind_q  <= sample_in.kind;
			known_q <= sample_in.known_weight;
			rej_q   <= 1'b0;
			neg_q   <= sum_n[SUM_W-1];
			dq_q    <= DVD_W'(sum_mag);
		end
		if (cmd.avg_mul) begin
			dq_q <= DVD_W'(avg_prod[AVG_P_W-1:RECIP_SH]);
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
		if (cmd.avg_fin) begin
			net_q <= net_n;
		end
		if (cmd.mul) begin
			prod_q <= net_q * scale_q;
		end
		if (cmd.cal_check) begin
			rej_q <= cal_reject;
			neg_q <= net_q[NET_W-1];
			dvs_q <= net_mag;
			dq_q  <= {known_q, {(DVD_W-KNOWN_W){1'b0}}};
			rem_q <= '0;
		end
		if (cmd.out_load) begin
			weight_q    <= weight_n;
			done_kind_q <= kind_q;
			rejected_q  <= rej_q;
			scale_out_q <= scale_q;
		end
	end

	assign result_out.valid                = out_valid_q;
	assign result_out.weight_q8            = weight_q;
	assign result_out.done_kind            = done_kind_q;
	assign result_out.calibration_rejected = rejected_q;
	assign result_out.scale_now            = scale_out_q;

	assign stat.take_done  = take && run_done;
	assign stat.div_last   = step_q == {STEP_W{1'b1}};
	assign stat.kind       = kind_q;
	assign stat.cal_reject = cal_reject;
	assign stat.out_free   = !out_valid_q || result_out.ready;

endmodule

[src/lcta_ctrl.sv]
// Controller: sequences averaging, multiply, calibration divide and result write.
module lcta_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  lcta_pkg::stat_t stat,
	output lcta_pkg::cmd_t  cmd
);
	import lcta_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_AVG_MUL = 8'b0000_0010,
		ST_AVG_FIN = 8'b0000_0100,
		ST_MUL     = 8'b0000_1000,
		ST_CAL_CHK = 8'b0001_0000,
		ST_CAL_DIV = 8'b0010_0000,
		ST_CAL_FIN = 8'b0100_0000,
		ST_WRITE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.take_done) state_n = ST_AVG_MUL;
			end
			ST_AVG_MUL: begin
				cmd.avg_mul = 1'b1;
				state_n = ST_AVG_FIN;
			end
			ST_AVG_FIN: begin
				cmd.avg_fin = 1'b1;
				if (stat.kind == KIND_MEASURE) begin
					state_n = ST_MUL;
				end else if (stat.kind == KIND_CAL) begin
					state_n = ST_CAL_CHK;
				end else begin
					state_n = ST_WRITE;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_WRITE;
			end
			ST_CAL_CHK: begin
				cmd.cal_check = 1'b1;
				state_n = stat.cal_reject ? ST_WRITE : ST_CAL_DIV;
			end
			ST_CAL_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_n = ST_CAL_FIN;
			end
			ST_CAL_FIN: begin
				cmd.cal_fin = 1'b1;
				state_n = ST_WRITE;
			end
			ST_WRITE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

[src/load_cell_tare_average_scale.sv]
// Load-cell tare, average and scale block: top level.
//
// sample_in carries one converter word per beat with its kind (measure, tare,
// calibrate), a timeout flag and the reference weight. Beats of one kind are
// summed into a run; a beat of another kind restarts the run, kind three is
// dropped. While the controller is idle, beats that do not finish a run
// stream at one per cycle.
// When a run finishes, result_out carries one beat: measure runs give the net
// weight (grams, 8 fraction bits), tare runs update the offset, calibrate runs
// update the scale or flag a rejection. The average is a reciprocal multiply;
// the calibration scale comes from a 32-step restoring divider.
// After a run finishes, no new beat is taken until its result is in the
// output register.
// If the receiver stalls, the result is held and the next run may still
// accumulate; a following finished run waits in the write state.
// Reset clears the run, the tare offset and restores the default scale.
module load_cell_tare_average_scale #(
	parameter int MEASURE_AVERAGE = lcta_pkg::MEASURE_AVERAGE_DEF,
	parameter int TARE_AVERAGE    = lcta_pkg::TARE_AVERAGE_DEF,
	parameter int SAMPLE_BITS     = lcta_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lcta_in_if.sink    sample_in,
	lcta_out_if.source result_out
);
	import lcta_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lcta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	lcta_datapath #(
		.MEASURE_AVERAGE (MEASURE_AVERAGE),
		.TARE_AVERAGE    (TARE_AVERAGE),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.result_out (result_out),
		.cmd        (cmd),
		.stat       (stat)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.avg_mul, cmd.div_step, cmd.avg_fin, cmd.mul, cmd.cal_check,
			cmd.cal_fin, cmd.out_load, cmd.in_ready}))
		else $error("more than one datapath command at once");

	a_weight_measure_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.done_kind != KIND_MEASURE |->
			result_out.weight_q8 == '0)
		else $error("non-measure beat with non-zero weight");

	a_reject_cal_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.done_kind != KIND_CAL |->
			!result_out.calibration_rejected)
		else $error("rejection flagged outside a calibrate run");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_out.valid)
		else $error("result beat lost after write");

endmodule
